// File: sv/wsq_pkg.sv
package wsq_pkg;

    localparam int unsigned BURST_W = 4;
    localparam logic [BURST_W-1:0] BURST_MAX = 4'd15;
    localparam logic [BURST_W-1:0] LIMIT_RESET = 4'd4;

    localparam int unsigned DATA_W = 32;

    // request codes; bit 1 set means serve
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_PREF = 2'd1;
    localparam logic [1:0] MODE_SERVE = 2'd2;
    localparam int unsigned MODE_SERVE_BIT = 1;

    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_SERVED = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic exec;
        logic cfg_wr;
    } t_cmd;

endpackage

// File: sv/wsq_fifo.sv
module wsq_fifo import wsq_pkg::*; #(
    parameter int unsigned DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_pop,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata,
    output logic              o_empty,
    output logic              o_full
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned FW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic [PW-1:0]     r_head;
    logic [PW-1:0]     n_head;
    logic [FW-1:0]     r_fill;
    logic [FW-1:0]     n_fill;
    logic [FW:0]       tail_sum;
    logic [PW-1:0]     tail;

    // tail wraps with one compare and subtract, head + fill stays below twice the depth
    always_comb begin
        tail_sum = (FW+1)'(r_head) + (FW+1)'(r_fill);
        if (tail_sum >= (FW+1)'(DEPTH)) begin
            tail_sum = tail_sum - (FW+1)'(DEPTH);
        end
        tail = tail_sum[PW-1:0];
    end

    assign o_empty = (r_fill == '0);
    assign o_full  = (r_fill == FW'(DEPTH));

    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        if (i_pop) begin
            n_head = (r_head == PW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_fill = r_fill - 1'b1;
        end else if (i_push) begin
            n_fill = r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[tail] <= i_wdata;
        end
        if (i_pop) begin
            r_rdata <= r_mem[r_head];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/wsq_dp.sv
module wsq_dp import wsq_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [1:0]               i_mode,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [BURST_W-1:0]       i_cfg_data,
    output logic [1:0]               o_status,
    output logic signed [DATA_W-1:0] o_served_value,
    output logic                     o_served_from_preferred
);

    logic [BURST_W-1:0] r_limit;
    logic [BURST_W-1:0] r_burst;
    logic [BURST_W-1:0] n_burst;
    logic [1:0]         r_status;
    logic [1:0]         n_status;
    logic               r_from_pref;
    logic               n_from_pref;

    logic              is_serve;
    logic              enq_pref;
    logic              take_pref;
    logic              push_norm;
    logic              push_pref;
    logic              pop_norm;
    logic              pop_pref;
    logic              norm_empty;
    logic              norm_full;
    logic              pref_empty;
    logic              pref_full;
    logic [DATA_W-1:0] norm_rdata;
    logic [DATA_W-1:0] pref_rdata;

    assign is_serve = i_mode[MODE_SERVE_BIT];
    assign enq_pref = (i_mode == MODE_PREF);

    always_comb begin
        n_burst   = r_burst;
        take_pref = 1'b0;
        if (pref_empty) begin
            take_pref = 1'b0;
        end else if (norm_empty) begin
            take_pref = 1'b1;
        end else if (r_burst > r_limit) begin
            take_pref = 1'b0;
            n_burst   = '0;
        end else begin
            take_pref = 1'b1;
            if (r_burst != BURST_MAX) begin
                n_burst = r_burst + 1'b1;
            end
        end

        push_norm   = 1'b0;
        push_pref   = 1'b0;
        pop_norm    = 1'b0;
        pop_pref    = 1'b0;
        n_from_pref = 1'b0;
        if (is_serve) begin
            if (norm_empty && pref_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_status    = ST_SERVED;
                pop_pref    = i_cmd.exec && take_pref;
                pop_norm    = i_cmd.exec && !take_pref;
                n_from_pref = take_pref;
            end
        end else if (enq_pref ? pref_full : norm_full) begin
            n_status = ST_FULL;
        end else begin
            n_status  = ST_ENQUEUED;
            push_pref = i_cmd.exec && enq_pref;
            push_norm = i_cmd.exec && !enq_pref;
        end
    end

    wsq_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_norm),
        .i_pop   (pop_norm),
        .i_wdata (i_value),
        .o_rdata (norm_rdata),
        .o_empty (norm_empty),
        .o_full  (norm_full)
    );

    wsq_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_pref (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_pref),
        .i_pop   (pop_pref),
        .i_wdata (i_value),
        .o_rdata (pref_rdata),
        .o_empty (pref_empty),
        .o_full  (pref_full)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_burst <= '0;
        end else begin
            if (i_cmd.cfg_wr) begin
                r_limit <= i_cfg_data;
            end
            // counter only moves on a serve with both queues waiting
            if (i_cmd.exec && is_serve) begin
                r_burst <= n_burst;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_from_pref <= n_from_pref;
        end
    end

    always_comb begin
        o_status                = r_status;
        o_served_from_preferred = 1'b0;
        o_served_value          = '0;
        if (r_status == ST_SERVED) begin
            o_served_from_preferred = r_from_pref;
            o_served_value = $signed(r_from_pref ? pref_rdata : norm_rdata);
        end
    end

endmodule

// File: sv/wsq_ctrl.sv
module wsq_ctrl import wsq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_stall,
    input  logic i_cfg_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    output logic o_cfg_ready,
    output t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_OUT  = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_cfg_ready  = 1'b1;
    assign o_cmd.exec   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.cfg_wr = i_cfg_valid;

endmodule

// File: sv/two_class_weighted_service_queue.sv
// latency: a result is valid in the cycle after its request transfers
// one request in flight: the single result register holds the next request off
//   until the current result transfers
// reset (synchronous, active low) empties both queues, clears the burst counter
//   and sets the burst limit to 4; queue storage contents are not cleared
module two_class_weighted_service_queue import wsq_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_mode,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_status,
    output logic signed [DATA_W-1:0] o_served_value,
    output logic                     o_served_from_preferred,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [BURST_W-1:0]       i_cfg_data
);

    t_cmd cmd;

    wsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    wsq_dp #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dp (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cmd                   (cmd),
        .i_mode                  (i_mode),
        .i_value                 (i_value),
        .i_cfg_data              (i_cfg_data),
        .o_status                (o_status),
        .o_served_value          (o_served_value),
        .o_served_from_preferred (o_served_from_preferred)
    );

endmodule

// File: sv/wsq_checker.sv
module wsq_checker import wsq_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic [1:0]               o_status,
    input logic signed [DATA_W-1:0] o_served_value,
    input logic                     o_served_from_preferred
);

    // every accepted request yields a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("no result after accepted request");

    // no new request while a result is waiting
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("request accepted while result pending");

    // non-served results carry zero value and no preferred flag
    a_unserved_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_SERVED) |->
            (o_served_value == '0 && !o_served_from_preferred))
        else $error("unserved result carries data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_served_value)
             && $stable(o_served_from_preferred)))
        else $error("stalled result changed");

endmodule

bind two_class_weighted_service_queue wsq_checker u_wsq_checker (
    .i_clk                   (i_clk),
    .i_rst_n                 (i_rst_n),
    .i_in_valid              (i_in_valid),
    .o_in_stall              (o_in_stall),
    .o_out_valid             (o_out_valid),
    .i_out_stall             (i_out_stall),
    .o_status                (o_status),
    .o_served_value          (o_served_value),
    .o_served_from_preferred (o_served_from_preferred)
);

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import wsq_pkg::*;

    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned PHASE_ITEMS = 140;
    localparam int unsigned NUM_PHASES = 8;
    // bit 1 set decodes serve, so the unused code acts as a second serve
    localparam logic [1:0] MODE_SERVE_ALT = 2'd3;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] value;
        logic              pref;
    } svc_result_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [DATA_W-1:0] value;
        logic [7:0]        reps;
        logic              typed;
        svc_result_t       want;
    } dir_row_t;

    localparam svc_result_t R_ENQ = '{ST_ENQUEUED, 32'd0, 1'b0};
    localparam svc_result_t R_EMPTY = '{ST_EMPTY, 32'd0, 1'b0};
    localparam svc_result_t R_FULL = '{ST_FULL, 32'd0, 1'b0};

    localparam int unsigned NUM_ROWS = 19;
    localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{MODE_SERVE,     32'h0000_0000, 8'd1,  1'b1, R_EMPTY},
        '{MODE_SERVE_ALT, 32'hFFFF_FFFF, 8'd1,  1'b1, R_EMPTY},
        '{MODE_NORMAL,    32'h7FFF_FFFF, 8'd1,  1'b1, R_ENQ},
        '{MODE_NORMAL,    32'h8000_0000, 8'd1,  1'b1, R_ENQ},
        '{MODE_PREF,      32'h0000_0000, 8'd1,  1'b1, R_ENQ},
        '{MODE_PREF,      32'hFFFF_FFFF, 8'd1,  1'b1, R_ENQ},
        '{MODE_SERVE,     32'h1234_5678, 8'd1,  1'b0, R_ENQ},
        '{MODE_SERVE_ALT, 32'h0000_0000, 8'd1,  1'b0, R_ENQ},
        '{MODE_SERVE,     32'h0000_0000, 8'd1,  1'b0, R_ENQ},
        '{MODE_SERVE,     32'h0000_0000, 8'd1,  1'b0, R_ENQ},
        '{MODE_SERVE,     32'h0000_0000, 8'd1,  1'b1, R_EMPTY},
        '{MODE_NORMAL,    32'h0000_1000, 8'd16, 1'b1, R_ENQ},
        '{MODE_NORMAL,    32'h5A5A_5A5A, 8'd1,  1'b1, R_FULL},
        '{MODE_PREF,      32'h0000_2000, 8'd16, 1'b1, R_ENQ},
        '{MODE_PREF,      32'hA5A5_A5A5, 8'd1,  1'b1, R_FULL},
        '{MODE_SERVE,     32'h0000_0000, 8'd12, 1'b0, R_ENQ},
        '{MODE_NORMAL,    32'hFFFF_FFFF, 8'd1,  1'b0, R_ENQ},
        '{MODE_SERVE,     32'h0000_0000, 8'd30, 1'b0, R_ENQ},
        '{MODE_SERVE,     32'h0000_0000, 8'd1,  1'b1, R_EMPTY}
    };

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_mode = MODE_NORMAL;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_served_value;
    logic                     o_served_from_preferred;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [BURST_W-1:0]       i_cfg_data = '0;

    // predictor state
    logic [DATA_W-1:0]  normal_q[$];
    logic [DATA_W-1:0]  pref_q[$];
    logic [BURST_W-1:0] burst_cnt;
    logic [BURST_W-1:0] burst_limit;

    svc_result_t pending_results[$];
    int unsigned mismatches = 0;
    int unsigned cycle_cnt = 0;
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;
    int unsigned stall_left = 0;

    two_class_weighted_service_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_in_valid              (i_in_valid),
        .o_in_stall              (o_in_stall),
        .i_mode                  (i_mode),
        .i_value                 (i_value),
        .o_out_valid             (o_out_valid),
        .i_out_stall             (i_out_stall),
        .o_status                (o_status),
        .o_served_value          (o_served_value),
        .o_served_from_preferred (o_served_from_preferred),
        .i_cfg_valid             (i_cfg_valid),
        .o_cfg_ready             (o_cfg_ready),
        .i_cfg_data              (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic svc_result_t predict_service(logic [1:0] mode, logic [DATA_W-1:0] value);
        svc_result_t res;
        bit          take_pref;
        res = '{ST_ENQUEUED, '0, 1'b0};
        if (!mode[MODE_SERVE_BIT]) begin
            if (mode == MODE_NORMAL) begin
                if (normal_q.size() >= QUEUE_DEPTH) res.status = ST_FULL;
                else normal_q.push_back(value);
            end else begin
                if (pref_q.size() >= QUEUE_DEPTH) res.status = ST_FULL;
                else pref_q.push_back(value);
            end
        end else if (normal_q.size() == 0 && pref_q.size() == 0) begin
            res.status = ST_EMPTY;
        end else begin
            if (pref_q.size() == 0) begin
                take_pref = 1'b0;
            end else if (normal_q.size() == 0) begin
                take_pref = 1'b1;
            end else if (burst_cnt > burst_limit) begin
                take_pref = 1'b0;
                burst_cnt = '0;
            end else begin
                take_pref = 1'b1;
                if (burst_cnt != BURST_MAX) burst_cnt = burst_cnt + 1'b1;
            end
            res.status = ST_SERVED;
            res.pref = take_pref;
            res.value = take_pref ? pref_q.pop_front() : normal_q.pop_front();
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // result side: compare every transfer against the oldest expectation
    always @(posedge i_clk) begin
        svc_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", {30'd0, o_status}, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", {30'd0, o_status}, {30'd0, want.status});
                if (o_served_value !== want.value)
                    report_mismatch("served_value", o_served_value, want.value);
                if (o_served_from_preferred !== want.pref)
                    report_mismatch("served_from_preferred", {31'd0, o_served_from_preferred},
                                    {31'd0, want.pref});
            end
        end
    end

    // result side stall: runs of random length, mostly short
    always @(negedge i_clk) begin
        int unsigned r;
        if (rx_quiet) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                i_out_stall <= 1'b0;
                stall_left <= $urandom_range(0, 7);
            end else if (r < 92) begin
                i_out_stall <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                stall_left <= $urandom_range(8, 30);
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_request(logic [1:0] mode, logic [DATA_W-1:0] value,
                                bit use_typed, svc_result_t typed_want);
        int unsigned gap;
        svc_result_t predicted;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_value <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = predict_service(mode, value);
        pending_results.push_back(use_typed ? typed_want : predicted);
        @(negedge i_clk);
    endtask

    task automatic write_burst_limit(logic [BURST_W-1:0] lim);
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= lim;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        burst_limit = lim;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [BURST_W-1:0] phase_limits [NUM_PHASES];
        int unsigned        enq_pct [NUM_PHASES];
        int unsigned        pref_pct;
        int unsigned        r;
        logic [1:0]         mode;
        logic [DATA_W-1:0]  value;

        phase_limits = '{BURST_MAX, 4'd0, 4'd9, BURST_MAX, 4'd0, 4'd2, LIMIT_RESET, 4'd1};
        enq_pct = '{70, 45, 55, 65, 40, 55, 75, 35};

        normal_q.delete();
        pref_q.delete();
        burst_cnt = '0;
        burst_limit = LIMIT_RESET;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            for (int k = 0; k < DIRECTED_ROWS[i].reps; k++)
                send_request(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].value + k,
                             DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end
        i_in_valid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            // a fresh random limit stands in for the fixed one in phase 5
            write_burst_limit(p == 5 ? BURST_W'($urandom_range(0, 15)) : phase_limits[p]);
            tx_quiet = (p == 3);
            rx_quiet = (p == 3);
            pref_pct = $urandom_range(30, 70);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < enq_pct[p])
                    mode = ($urandom_range(0, 99) < pref_pct) ? MODE_PREF : MODE_NORMAL;
                else
                    mode = ($urandom_range(0, 9) == 0) ? MODE_SERVE_ALT : MODE_SERVE;
                r = $urandom_range(0, 19);
                if (r == 0) value = 32'h7FFF_FFFF;
                else if (r == 1) value = 32'h8000_0000;
                else if (r == 2) value = 32'hFFFF_FFFF;
                else value = $urandom;
                send_request(mode, value, 1'b0, R_ENQ);
            end
            i_in_valid <= 1'b0;
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results left over", pending_results.size(), '0);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
